// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VTP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vtp assertion failed");

// Condition that must never be true outside reset.
`define VTP_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("vtp forbidden condition seen");

`endif

// ===== design/vtp_pkg.sv =====
// Package with constants, types and helpers of the vertex transform core.
package vtp_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 12;
    // Magnitude of coordinate times view distance stays below 2^30.
    localparam int DIV_BITS    = 30;
    // Magnitude of view distance minus z stays below 2^16.
    localparam int DEN_BITS    = 16;
    localparam int SUM_BITS    = 35;

    typedef enum logic [2:0] {
        CFG_X_COEFFS  = 3'd0,
        CFG_Y_COEFFS  = 3'd1,
        CFG_Z_COEFFS  = 3'd2,
        CFG_VIEW_DIST = 3'd3,
        CFG_CENTER_X  = 3'd4,
        CFG_CENTER_Y  = 3'd5
    } cfg_index_t;

    // Control handed to the divider pipeline.
    typedef struct packed {
        logic adv;
    } div_ctrl_t;

    // Per-item data that travels alongside the divider.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] tx;
        logic signed [COORD_WIDTH-1:0] ty;
        logic signed [COORD_WIDTH-1:0] tz;
        logic                          neg_x;
        logic                          neg_y;
        logic                          fault;
    } side_t;

    // Saturate a wide signed value to the coordinate width.
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'((64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1);
        lo = -hi - SUM_BITS'(1);
        if (v > hi)
            sat_coord = hi[COORD_WIDTH-1:0];
        else if (v < lo)
            sat_coord = lo[COORD_WIDTH-1:0];
        else
            sat_coord = v[COORD_WIDTH-1:0];
    endfunction

endpackage

// ===== design/vtp_divider.sv =====
// Pipelined two-lane restoring divider, one quotient bit per stage.
module vtp_divider (
    input  logic                            clk,
    input  vtp_pkg::div_ctrl_t              ctrl,
    input  logic [vtp_pkg::DIV_BITS-1:0]    num_a,
    input  logic [vtp_pkg::DIV_BITS-1:0]    num_b,
    input  logic [vtp_pkg::DEN_BITS-1:0]    divisor,
    output logic [vtp_pkg::DIV_BITS-1:0]    quo_a,
    output logic [vtp_pkg::DIV_BITS-1:0]    quo_b
);

    logic [vtp_pkg::DEN_BITS-1:0] rem_a_reg  [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DEN_BITS-1:0] rem_b_reg  [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DIV_BITS-1:0] num_a_reg  [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DIV_BITS-1:0] num_b_reg  [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DEN_BITS-1:0] div_reg    [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DEN_BITS-1:0] rem_a_next [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DEN_BITS-1:0] rem_b_next [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DIV_BITS-1:0] num_a_next [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DIV_BITS-1:0] num_b_next [vtp_pkg::DIV_BITS];
    logic [vtp_pkg::DEN_BITS-1:0] div_next   [vtp_pkg::DIV_BITS];

    // One restoring step: the quotient bit shifts in where the dividend bit left.
    function automatic logic [vtp_pkg::DEN_BITS+vtp_pkg::DIV_BITS-1:0] div_step(
        input logic [vtp_pkg::DEN_BITS-1:0] rem,
        input logic [vtp_pkg::DIV_BITS-1:0] num,
        input logic [vtp_pkg::DEN_BITS-1:0] dv);
        logic [vtp_pkg::DEN_BITS:0]   trial;
        logic [vtp_pkg::DEN_BITS-1:0] rem_o;
        logic                         qbit;
        trial = {rem, num[vtp_pkg::DIV_BITS-1]};
        if (trial >= {1'b0, dv})
        begin
            trial = trial - {1'b0, dv};
            qbit  = 1'b1;
        end
        else
        begin
            qbit = 1'b0;
        end
        rem_o    = trial[vtp_pkg::DEN_BITS-1:0];
        div_step = {rem_o, num[vtp_pkg::DIV_BITS-2:0], qbit};
    endfunction

    // Each stage works on the registers of the stage before it.
    always_comb
    begin
        for (int s = 0; s < vtp_pkg::DIV_BITS; s++)
        begin
            if (s == 0)
            begin
                {rem_a_next[s], num_a_next[s]} =
                    div_step('0, num_a, divisor);
                {rem_b_next[s], num_b_next[s]} =
                    div_step('0, num_b, divisor);
                div_next[s] = divisor;
            end
            else
            begin
                {rem_a_next[s], num_a_next[s]} =
                    div_step(rem_a_reg[s-1], num_a_reg[s-1], div_reg[s-1]);
                {rem_b_next[s], num_b_next[s]} =
                    div_step(rem_b_reg[s-1], num_b_reg[s-1], div_reg[s-1]);
                div_next[s] = div_reg[s-1];
            end
        end
    end

    // Stage registers move only when the whole pipeline advances.
    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            for (int s = 0; s < vtp_pkg::DIV_BITS; s++)
            begin
                rem_a_reg[s] <= rem_a_next[s];
                rem_b_reg[s] <= rem_b_next[s];
                num_a_reg[s] <= num_a_next[s];
                num_b_reg[s] <= num_b_next[s];
                div_reg[s]   <= div_next[s];
            end
        end
    end

    assign quo_a = num_a_reg[vtp_pkg::DIV_BITS-1];
    assign quo_b = num_b_reg[vtp_pkg::DIV_BITS-1];

endmodule

// ===== design/vertex_transform_project_core.sv =====
// Top level: affine transform and perspective projection of one point per item.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  in       | into core | in_valid/in_stall  | in_x, in_y, in_z
//  out      | out       | out_valid/out_stall| out3_x/y/z, screen_x/y, divide_fault
//  cfg      | into core | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle is accepted while in_stall is low; each item passes 36 register
// stages: the 30-stage divider plus five arithmetic stages and the output register.
// Reset clears all valid bits and loads the register defaults. A stall on the
// output while out_valid is high freezes the whole pipeline and raises in_stall.
`include "assert_macros.svh"

module vertex_transform_project_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] in_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] out3_x,
    output logic signed [15:0] out3_y,
    output logic signed [15:0] out3_z,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic        divide_fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = vtp_pkg::COORD_WIDTH;
    localparam int SW = vtp_pkg::SUM_BITS;
    localparam int NB = vtp_pkg::DIV_BITS;

    // Configuration registers.
    logic [63:0] xc_reg, yc_reg, zc_reg;
    logic [14:0] vd_reg;
    logic signed [15:0] cx_reg, cy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xc_reg <= 64'h0000_0000_0000_1000;
            yc_reg <= 64'h0000_0000_1000_0000;
            zc_reg <= 64'h0000_1000_0000_0000;
            vd_reg <= 15'd256;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vtp_pkg::CFG_X_COEFFS:  xc_reg <= cfg_data;
                vtp_pkg::CFG_Y_COEFFS:  yc_reg <= cfg_data;
                vtp_pkg::CFG_Z_COEFFS:  zc_reg <= cfg_data;
                vtp_pkg::CFG_VIEW_DIST: vd_reg <= cfg_data[14:0];
                vtp_pkg::CFG_CENTER_X:  cx_reg <= cfg_data[15:0];
                vtp_pkg::CFG_CENTER_Y:  cy_reg <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    // Pipeline advance: everything moves when the output slot is free or taken.
    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [NB-1:0] vd_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            vd_pipe_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            vd_pipe_reg   <= {vd_pipe_reg[NB-2:0], v5_reg};
            out_valid_reg <= vd_pipe_reg[NB-1];
        end
    end

    // Stage 1: nine coefficient products.
    logic signed [31:0] p_reg [3][3];
    logic [63:0] coef [3];
    assign coef[0] = xc_reg;
    assign coef[1] = yc_reg;
    assign coef[2] = zc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                p_reg[r][0] <= $signed(coef[r][15:0])  * in_x;
                p_reg[r][1] <= $signed(coef[r][31:16]) * in_y;
                p_reg[r][2] <= $signed(coef[r][47:32]) * in_z;
            end
        end
    end

    // Stage 2: sum of products plus translation in fixed point.
    logic signed [SW-1:0] s_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s_reg[r] <= SW'(p_reg[r][0]) + SW'(p_reg[r][1]) + SW'(p_reg[r][2])
                          + (SW'($signed(coef[r][63:48])) <<< vtp_pkg::FRAC_BITS);
            end
        end
    end

    // Stage 3: drop the fraction toward zero and saturate.
    logic signed [CW-1:0] t_reg [3];
    logic signed [SW-1:0] biased [3];
    localparam logic signed [SW-1:0] FRAC_MASK = SW'((1 << vtp_pkg::FRAC_BITS) - 1);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            biased[r] = s_reg[r][SW-1] ? s_reg[r] + FRAC_MASK : s_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                t_reg[r] <= vtp_pkg::sat_coord(biased[r] >>> vtp_pkg::FRAC_BITS);
            end
        end
    end

    // Stage 4: numerators and denominator of the projection.
    logic signed [31:0] nx_reg, ny_reg;
    logic signed [17:0] den_reg;
    logic signed [CW-1:0] tx4_reg, ty4_reg, tz4_reg;
    logic signed [15:0] vd_s;
    assign vd_s = $signed({1'b0, vd_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg  <= t_reg[0] * vd_s;
            ny_reg  <= t_reg[1] * vd_s;
            den_reg <= 18'(vd_s) - 18'(t_reg[2]);
            tx4_reg <= t_reg[0];
            ty4_reg <= t_reg[1];
            tz4_reg <= t_reg[2];
        end
    end

    // Stage 5: magnitudes and result signs for the unsigned divider.
    logic [NB-1:0] mx_reg, my_reg;
    logic [vtp_pkg::DEN_BITS-1:0] md_reg;
    vtp_pkg::side_t side5_reg;
    logic signed [31:0] anx, any_v;
    logic signed [17:0] aden;

    always_comb
    begin
        anx   = nx_reg[31] ? -nx_reg : nx_reg;
        any_v = ny_reg[31] ? -ny_reg : ny_reg;
        aden  = den_reg[17] ? -den_reg : den_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg          <= anx[NB-1:0];
            my_reg          <= any_v[NB-1:0];
            md_reg          <= aden[vtp_pkg::DEN_BITS-1:0];
            side5_reg.tx    <= tx4_reg;
            side5_reg.ty    <= ty4_reg;
            side5_reg.tz    <= tz4_reg;
            side5_reg.neg_x <= nx_reg[31] ^ den_reg[17];
            side5_reg.neg_y <= ny_reg[31] ^ den_reg[17];
            side5_reg.fault <= (den_reg == '0);
        end
    end

    // Divider and the side data that keeps pace with it.
    vtp_pkg::div_ctrl_t div_ctrl;
    logic [NB-1:0] qx, qy;
    vtp_pkg::side_t side_reg [NB];

    assign div_ctrl.adv = adv;

    vtp_divider u_div (
        .clk     (clk),
        .ctrl    (div_ctrl),
        .num_a   (mx_reg),
        .num_b   (my_reg),
        .divisor (md_reg),
        .quo_a   (qx),
        .quo_b   (qy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side5_reg;
            for (int s = 1; s < NB; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // Output stage: restore sign, add center, saturate; a faulted item gets the center.
    vtp_pkg::side_t sd;
    logic signed [SW-1:0] sqx, sqy;
    logic signed [CW-1:0] sx_next, sy_next;
    logic signed [CW-1:0] o3x_reg, o3y_reg, o3z_reg, sx_reg, sy_reg;
    logic fault_reg;

    always_comb
    begin
        sd  = side_reg[NB-1];
        sqx = sd.neg_x ? -SW'(qx) : SW'(qx);
        sqy = sd.neg_y ? -SW'(qy) : SW'(qy);
        if (sd.fault)
        begin
            sx_next = cx_reg;
            sy_next = cy_reg;
        end
        else
        begin
            sx_next = vtp_pkg::sat_coord(sqx + SW'(cx_reg));
            sy_next = vtp_pkg::sat_coord(sqy + SW'(cy_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o3x_reg   <= sd.tx;
            o3y_reg   <= sd.ty;
            o3z_reg   <= sd.tz;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            fault_reg <= sd.fault;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out3_x       = o3x_reg;
    assign out3_y       = o3y_reg;
    assign out3_z       = o3z_reg;
    assign screen_x     = sx_reg;
    assign screen_y     = sy_reg;
    assign divide_fault = fault_reg;

    // A faulted item shows the center point on the screen outputs.
    `VTP_ASSERT(a_fault_center, clk, rst_n,
        (out_valid && divide_fault) |-> (screen_x == cx_reg && screen_y == cy_reg))
    // The input is held off only while a result waits on the output.
    `VTP_NEVER(a_stall_cause, clk, rst_n, in_stall && !out_valid)
    // A held result stays valid in the next cycle.
    `VTP_ASSERT(a_hold_valid, clk, rst_n, (out_valid && out_stall) |=> out_valid)

endmodule

// ===== verif/tb_vertex_transform_project_core.sv =====
// Testbench for the vertex transform and projection core.
module tb_vertex_transform_project_core;

    timeunit 1ns;
    timeprecision 1ps;

    // Result fields of one item.
    typedef struct {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               fault;
    } vertex_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] out3_x;
    logic signed [15:0] out3_y;
    logic signed [15:0] out3_z;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               divide_fault;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;

    // Shadow copy of the configuration registers.
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [14:0] eye_dist;
    logic [15:0] ctr_x;
    logic [15:0] ctr_y;

    vertex_result_t expected_vertices[$];
    int mismatch_count;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;

    vertex_transform_project_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .in_x(in_x), .in_y(in_y), .in_z(in_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .out3_x(out3_x), .out3_y(out3_y), .out3_z(out3_z),
        .screen_x(screen_x), .screen_y(screen_y), .divide_fault(divide_fault),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Clamp a wide signed value to the 16-bit coordinate range.
    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // One affine row: exact sum, divide by 2^12 toward zero, clamp.
    function automatic logic signed [15:0] affine_row(input logic [63:0] r,
        input longint x, input longint y, input longint z);
        longint s;
        s = longint'($signed(r[15:0])) * x + longint'($signed(r[31:16])) * y
            + longint'($signed(r[47:32])) * z + longint'($signed(r[63:48])) * 4096;
        return clamp16(s / 4096);
    endfunction

    function automatic vertex_result_t transform_vertex(input logic signed [15:0] x,
        input logic signed [15:0] y, input logic signed [15:0] z);
        vertex_result_t r;
        longint d;
        longint den;
        r.tx = affine_row(row_x, x, y, z);
        r.ty = affine_row(row_y, x, y, z);
        r.tz = affine_row(row_z, x, y, z);
        d = eye_dist;
        den = d - longint'(r.tz);
        r.fault = (den == 0);
        if (r.fault)
        begin
            r.sx = $signed(ctr_x);
            r.sy = $signed(ctr_y);
        end
        else
        begin
            r.sx = clamp16((longint'(r.tx) * d) / den + longint'($signed(ctr_x)));
            r.sy = clamp16((longint'(r.ty) * d) / den + longint'($signed(ctr_y)));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Send one point; the prediction is pushed when it is accepted.
    // The valid stays high afterwards so that items can follow back to back;
    // drain and write_reg take it down.
    task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
        input logic signed [15:0] z);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_vertices.push_back(transform_vertex(x, y, z));
    endtask

    task automatic send_random_vertex();
        send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Wait until every result is in, then let the pipeline drain.
    task automatic drain();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write one register; the valid is taken down by the next task.
    task automatic write_reg(input vtp_pkg::cfg_index_t idx, input logic [63:0] v);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            vtp_pkg::CFG_X_COEFFS:  row_x = v;
            vtp_pkg::CFG_Y_COEFFS:  row_y = v;
            vtp_pkg::CFG_Z_COEFFS:  row_z = v;
            vtp_pkg::CFG_VIEW_DIST: eye_dist = v[14:0];
            vtp_pkg::CFG_CENTER_X:  ctr_x = v[15:0];
            vtp_pkg::CFG_CENTER_Y:  ctr_y = v[15:0];
            default: ;
        endcase
    endtask

    // Pack three Q3.12 coefficients and a translation.
    function automatic logic [63:0] row(input int cx, input int cy, input int cz,
        input int t);
        return {t[15:0], cz[15:0], cy[15:0], cx[15:0]};
    endfunction

    task automatic write_random_config();
        write_reg(vtp_pkg::CFG_X_COEFFS, {$urandom, $urandom});
        write_reg(vtp_pkg::CFG_Y_COEFFS, {$urandom, $urandom});
        write_reg(vtp_pkg::CFG_Z_COEFFS, {$urandom, $urandom});
        write_reg(vtp_pkg::CFG_VIEW_DIST, 64'($urandom_range(32767, 0)));
        write_reg(vtp_pkg::CFG_CENTER_X, 64'($urandom));
        write_reg(vtp_pkg::CFG_CENTER_Y, 64'($urandom));
    endtask

    // Extremes of the coordinates under the reset configuration.
    task automatic test_reset_extremes();
        send_vertex(0, 0, 0);
        send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sh7fff, 16'sh8000, 16'sh0100);
        send_vertex(-1, 1, 255);
        send_vertex(100, -100, 16'sh8000);
        drain();
    endtask

    // Zero denominator, zero view distance and saturation cases.
    task automatic test_special_cases();
        write_reg(vtp_pkg::CFG_CENTER_X, 64'h8000);
        write_reg(vtp_pkg::CFG_CENTER_Y, 64'h7fff);
        send_vertex(5, 7, 256);
        send_vertex(-3, 9, 255);
        drain();
        write_reg(vtp_pkg::CFG_VIEW_DIST, 64'd0);
        send_vertex(123, -45, 0);
        send_vertex(123, -45, 7);
        drain();
        write_reg(vtp_pkg::CFG_VIEW_DIST, 64'd32767);
        write_reg(vtp_pkg::CFG_X_COEFFS, row(32767, 32767, 32767, 32767));
        write_reg(vtp_pkg::CFG_Y_COEFFS, row(-32768, -32768, -32768, -32768));
        write_reg(vtp_pkg::CFG_Z_COEFFS, row(-32768, 0, 0, 32767));
        send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(-1, -1, -1);
        send_vertex(1, 1, 1);
        drain();
        // Translation only, z placed on the view distance.
        write_reg(vtp_pkg::CFG_X_COEFFS, row(0, 0, 0, -5));
        write_reg(vtp_pkg::CFG_Y_COEFFS, row(0, 0, 0, 5));
        write_reg(vtp_pkg::CFG_Z_COEFFS, row(0, 0, 0, 1000));
        write_reg(vtp_pkg::CFG_VIEW_DIST, 64'd1000);
        send_vertex(1, 2, 3);
        drain();
        write_reg(vtp_pkg::CFG_VIEW_DIST, 64'd1);
        send_vertex(1, 2, 3);
        drain();
    endtask

    // Random points under random configurations and idling patterns.
    task automatic test_random_phases();
        int pcts[4][2];
        pcts = '{'{0, 0}, '{65, 0}, '{0, 65}, '{29, 29}};
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = pcts[ph % 4][0];
            stall_pct = pcts[ph % 4][1];
            if (ph % 2 == 1)
            begin
                // Plausible transforms keep most points off saturation.
                write_reg(vtp_pkg::CFG_X_COEFFS, row($urandom_range(8192) - 4096,
                    $urandom_range(8192) - 4096, $urandom_range(512) - 256, $urandom));
                write_reg(vtp_pkg::CFG_Y_COEFFS, row($urandom_range(512) - 256,
                    $urandom_range(8192) - 4096, $urandom_range(512) - 256, $urandom));
                write_reg(vtp_pkg::CFG_Z_COEFFS, row(0, 0, $urandom_range(8192) - 4096,
                    $urandom_range(200) - 100));
                write_reg(vtp_pkg::CFG_VIEW_DIST, 64'($urandom_range(32767, 1)));
                write_reg(vtp_pkg::CFG_CENTER_X, 64'($urandom));
                write_reg(vtp_pkg::CFG_CENTER_Y, 64'($urandom));
            end
            else
                write_random_config();
            for (int i = 0; i < 120; i++)
                if (i % 5 == 0)
                    send_vertex(16'($urandom_range(300) - 150),
                        16'($urandom_range(300) - 150),
                        $signed(16'(eye_dist)) - 16'($urandom_range(2)));
                else
                    send_random_vertex();
            drain();
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // Long receiver hold-off fills the pipeline, then the sender waits it out.
    task automatic test_backpressure();
        hold_cycles = 120;
        for (int i = 0; i < 60; i++)
            send_random_vertex();
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 20; i++)
            send_random_vertex();
        drain();
    endtask

    // Receiver stall: random per cycle, or held for a counted stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        vertex_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
                report_mismatch("result with no item outstanding");
            else
            begin
                e = expected_vertices.pop_front();
                if (out3_x !== e.tx)
                    report_mismatch($sformatf("out3_x %0d exp %0d", out3_x, e.tx));
                if (out3_y !== e.ty)
                    report_mismatch($sformatf("out3_y %0d exp %0d", out3_y, e.ty));
                if (out3_z !== e.tz)
                    report_mismatch($sformatf("out3_z %0d exp %0d", out3_z, e.tz));
                if (screen_x !== e.sx)
                    report_mismatch($sformatf("screen_x %0d exp %0d", screen_x, e.sx));
                if (screen_y !== e.sy)
                    report_mismatch($sformatf("screen_y %0d exp %0d", screen_y, e.sy));
                if (divide_fault !== e.fault)
                    report_mismatch($sformatf("divide_fault %0b exp %0b",
                        divide_fault, e.fault));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        cfg_valid = 1'b0;
        cfg_index = vtp_pkg::CFG_X_COEFFS;
        cfg_data = '0;
        mismatch_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        row_x = 64'd4096;
        row_y = 64'd4096 << 16;
        row_z = 64'd4096 << 32;
        eye_dist = 15'd256;
        ctr_x = '0;
        ctr_y = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_extremes();
        test_special_cases();
        test_random_phases();
        test_backpressure();
        if (expected_vertices.size() != 0)
            report_mismatch("results missing at end of run");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #200000;
        $display("Mismatches found");
        $finish;
    end
endmodule
